/* sv/register_read_coalescer_unit_macros.svh */
// Assertion macros for the read coalescer
`ifndef REGISTER_READ_COALESCER_UNIT_MACROS_SVH
`define REGISTER_READ_COALESCER_UNIT_MACROS_SVH

// implication checked every cycle outside reset
`define RRC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication checked on the following cycle
`define RRC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/rrc_pkg.sv */
package rrc_pkg;

  typedef struct packed {
    logic [7:0]  code;
    logic [15:0] addr;
    logic [6:0]  cnt;
  } point_t;

  // word carried from the sorter to the merger
  typedef struct packed {
    point_t pt;
    logic   last;
    logic   ovf;
  } qword_t;

  typedef enum logic {
    FR_LOAD,
    FR_DRAIN
  } front_state_t;

  typedef enum logic [1:0] {
    BK_EMPTY,
    BK_GROUP,
    BK_FLUSH
  } back_state_t;

  localparam logic [7:0] GAP_RESET = 8'd5;

endpackage

/* sv/rrc_sorter.sv */
module rrc_sorter #(
  parameter int MAX_POINTS = 64
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  output logic           full,
  input  rrc_pkg::point_t in_pt,
  input  logic           in_last,
  output logic           q_valid,
  input  logic           q_ready,
  output rrc_pkg::qword_t q_word,
  output logic           draining
);

  localparam int CW = $clog2(MAX_POINTS + 1);

  rrc_pkg::point_t pt_row [MAX_POINTS];
  logic [CW-1:0] count;
  logic          ovf;
  rrc_pkg::front_state_t state, state_next;
  logic [MAX_POINTS-1:0] gt;
  logic accept, store_ok, shift_out;

  assign accept    = push && !full;
  assign store_ok  = count < CW'(MAX_POINTS);
  assign shift_out = (state == rrc_pkg::FR_DRAIN) && q_ready;

  // cells stay sorted; gt marks those that move up one place
  always_comb begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      gt[i] = (CW'(i) < count) && (pt_row[i] > in_pt);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_POINTS; i++) begin
      if (accept && store_ok) begin
        if (gt[i] || !(CW'(i) < count)) begin
          if (i > 0 && gt[(i > 0) ? i - 1 : 0]) begin
            pt_row[i] <= pt_row[(i > 0) ? i - 1 : 0];
          end else begin
            pt_row[i] <= in_pt;
          end
        end
      end else if (shift_out && i < MAX_POINTS - 1) begin
        pt_row[i] <= pt_row[(i < MAX_POINTS - 1) ? i + 1 : i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= rrc_pkg::FR_LOAD;
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        if (store_ok) begin
          count <= count + 1'b1;
        end else begin
          ovf <= 1'b1;
        end
      end else if (shift_out) begin
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          ovf <= 1'b0;
        end
      end
    end
  end

  always_comb begin
    state_next = state;
    full       = 1'b0;
    q_valid    = 1'b0;
    unique case (state)
      rrc_pkg::FR_LOAD: begin
        if (accept && in_last) begin
          state_next = rrc_pkg::FR_DRAIN;
        end
      end
      rrc_pkg::FR_DRAIN: begin
        full    = 1'b1;
        q_valid = 1'b1;
        if (q_ready && count == CW'(1)) begin
          state_next = rrc_pkg::FR_LOAD;
        end
      end
      default: state_next = rrc_pkg::FR_LOAD;
    endcase
  end

  assign q_word.pt   = pt_row[0];
  assign q_word.last = (count == CW'(1));
  assign q_word.ovf  = ovf;
  assign draining    = (state == rrc_pkg::FR_DRAIN);

endmodule

/* sv/rrc_queue.sv */
module rrc_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  rrc_pkg::qword_t wr_word,
  output logic           rd_valid,
  input  logic           rd_take,
  output rrc_pkg::qword_t rd_word
);

  rrc_pkg::qword_t slot [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] used;
  logic       do_wr, do_rd;

  assign wr_ready = (used != 2'd2);
  assign rd_valid = (used != 2'd0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_take && rd_valid;
  assign rd_word  = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slot[wr_ptr] <= wr_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      used   <= 2'd0;
    end else begin
      if (do_wr) wr_ptr <= !wr_ptr;
      if (do_rd) rd_ptr <= !rd_ptr;
      used <= used + {1'b0, do_wr} - {1'b0, do_rd};
    end
  end

endmodule

/* sv/rrc_merger.sv */
module rrc_merger (
  input  logic           clk,
  input  logic           rst,
  input  logic [7:0]     merge_gap,
  input  logic           q_valid,
  output logic           q_take,
  input  rrc_pkg::qword_t q_word,
  output logic           empty,
  input  logic           pop,
  output logic [7:0]     group_code,
  output logic [15:0]    group_start,
  output logic [16:0]    register_span,
  output logic [6:0]     point_total,
  output logic           last_group,
  output logic           dropped,
  output logic           flushing
);

  rrc_pkg::back_state_t state, state_next;
  logic [7:0]  cur_code;
  logic [15:0] acc_start;
  logic [16:0] cur_end;
  logic [6:0]  cur_total;
  logic        cur_ovf;
  logic        out_valid;
  logic        room, join_pt, emit, emit_last, load_new, grow;
  logic [16:0] p_end;
  logic [17:0] reach;

  assign room  = !out_valid || pop;
  assign p_end = {1'b0, q_word.pt.addr} + 17'(q_word.pt.cnt);
  assign reach = {1'b0, cur_end} + 18'(merge_gap);
  assign join_pt = (q_word.pt.code == cur_code) && ({2'b00, q_word.pt.addr} <= reach);

  always_comb begin
    state_next = state;
    q_take     = 1'b0;
    emit       = 1'b0;
    emit_last  = 1'b0;
    load_new   = 1'b0;
    grow       = 1'b0;
    unique case (state)
      rrc_pkg::BK_EMPTY: begin
        if (q_valid) begin
          q_take     = 1'b1;
          load_new   = 1'b1;
          state_next = q_word.last ? rrc_pkg::BK_FLUSH : rrc_pkg::BK_GROUP;
        end
      end
      rrc_pkg::BK_GROUP: begin
        if (q_valid && join_pt) begin
          q_take = 1'b1;
          grow   = 1'b1;
          if (q_word.last) state_next = rrc_pkg::BK_FLUSH;
        end else if (q_valid && room) begin
          // gap too wide or new code: close the group, open another
          q_take   = 1'b1;
          emit     = 1'b1;
          load_new = 1'b1;
          if (q_word.last) state_next = rrc_pkg::BK_FLUSH;
        end
      end
      rrc_pkg::BK_FLUSH: begin
        if (room) begin
          emit       = 1'b1;
          emit_last  = 1'b1;
          state_next = rrc_pkg::BK_EMPTY;
        end
      end
      default: state_next = rrc_pkg::BK_EMPTY;
    endcase
  end

  always_ff @(posedge clk) begin
    if (load_new) begin
      cur_code  <= q_word.pt.code;
      acc_start <= q_word.pt.addr;
      cur_end   <= p_end;
      cur_total <= 7'd1;
      cur_ovf   <= q_word.ovf;
    end else if (grow) begin
      if (p_end > cur_end) cur_end <= p_end;
      cur_total <= cur_total + 7'd1;
    end
    if (emit) begin
      group_code    <= cur_code;
      group_start   <= acc_start;
      register_span <= cur_end - {1'b0, acc_start};
      point_total   <= cur_total;
      last_group    <= emit_last;
      dropped       <= cur_ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= rrc_pkg::BK_EMPTY;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign empty    = !out_valid;
  assign flushing = (state == rrc_pkg::BK_FLUSH);

endmodule

/* sv/register_read_coalescer_unit.sv */
// Points load at one word per cycle while the run is open.
// After the last point the sorted store drains one point per cycle to the merger
// while the queue in front of the merger has room.
// Sorting is done on load by an insertion row of MAX_POINTS cells.
// Synchronous reset empties the store and the queue and sets merge_gap to 5.
module register_read_coalescer_unit #(
  parameter int MAX_POINTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  point_code,
  input  logic [15:0] point_addr,
  input  logic [6:0]  point_count,
  input  logic        last_point,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  group_code,
  output logic [15:0] group_start,
  output logic [16:0] register_span,
  output logic [6:0]  point_total,
  output logic        last_group,
  output logic        dropped,
  input  logic        merge_gap_we,
  input  logic [7:0]  merge_gap_wdata
);

  `include "register_read_coalescer_unit_macros.svh"

  logic [7:0] merge_gap;
  rrc_pkg::point_t in_pt;
  rrc_pkg::qword_t s_word, m_word;
  logic s_valid, s_ready, m_valid, m_take, draining, flushing;

  always_ff @(posedge clk) begin
    if (rst) begin
      merge_gap <= rrc_pkg::GAP_RESET;
    end else if (merge_gap_we) begin
      merge_gap <= merge_gap_wdata;
    end
  end

  assign in_pt.code = point_code;
  assign in_pt.addr = point_addr;
  assign in_pt.cnt  = point_count;

  rrc_sorter #(.MAX_POINTS(MAX_POINTS)) u_sorter (
    .clk, .rst, .push, .full, .in_pt, .in_last(last_point),
    .q_valid(s_valid), .q_ready(s_ready), .q_word(s_word), .draining
  );

  rrc_queue u_queue (
    .clk, .rst, .wr_valid(s_valid), .wr_ready(s_ready), .wr_word(s_word),
    .rd_valid(m_valid), .rd_take(m_take), .rd_word(m_word)
  );

  rrc_merger u_merger (
    .clk, .rst, .merge_gap, .q_valid(m_valid), .q_take(m_take), .q_word(m_word),
    .empty, .pop, .group_code, .group_start, .register_span, .point_total,
    .last_group, .dropped, .flushing
  );

  `RRC_ASSERT_IMP(a_drain_blocks_input, draining, full, "input open while draining")
  `RRC_ASSERT_IMP(a_flush_no_take, flushing, !m_take, "merger took a word while flushing")
  `RRC_ASSERT_NEXT(a_last_starts_drain, push && !full && last_point, draining, "no drain")

endmodule
